[hdl/assert_macros.svh]
// Assertion macros used by the strip driver datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

[hdl/ws_pkg.sv]
// Types and constants shared by the strip driver modules.
package ws_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FILL  = 2'd2,
    OP_SHOW  = 2'd3
  } op_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int TIME_W     = 12;
  localparam int COUNT_W    = 9;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TIME_ZERO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TIME_ONE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT      = 2'd3;

  localparam logic [TIME_W-1:0]  RST_HIGH_TIME_ZERO = 12'd32;
  localparam logic [TIME_W-1:0]  RST_HIGH_TIME_ONE  = 12'd64;
  localparam logic [TIME_W-1:0]  RST_BIT_PERIOD     = 12'd100;
  localparam logic [COUNT_W-1:0] RST_LED_COUNT      = 9'd256;

  // Color channel within a pixel: green, red, blue.
  localparam logic [1:0] CHAN_GREEN = 2'd0;
  localparam logic [1:0] CHAN_RED   = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;

  localparam logic [2:0] BIT_MSB = 3'd7;

  typedef struct packed {
    logic latch;       // capture the accepted beat and read the current pixel
    logic exec;        // carry out the captured operation
    logic fill_start;  // start a fill sweep at entry zero
    logic fill_step;   // write one entry of the fill sweep
    logic out_next;    // load the result stage from the values being committed
    logic out_reg;     // load the result stage from the committed registers
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic sending;
    logic n_zero;
    logic fill_last;
    logic out_free;
  } stat_t;

endpackage

[hdl/ws_if.sv]
// Valid/ready channel interfaces for operation beats and result beats.
interface ws_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] pixel_index;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] blue;

  modport source (output valid, output op, output pixel_index, output green,
                  output red, output blue, input ready);
  modport sink (input valid, input op, input pixel_index, input green,
                input red, input blue, output ready);
endinterface

interface ws_out_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic accepted;

  modport source (output valid, output pin_level, output busy_res, output accepted,
                  input ready);
  modport sink (input valid, input pin_level, input busy_res, input accepted,
                output ready);
endinterface

[hdl/ws2812_strip_driver_core.sv]
// Top level of the serial LED strip driver.
//
// This block drives a single-wire serial LED strip from a pixel memory of
// LEDS entries, each holding a green, red and blue byte. Every beat on the
// item channel carries one operation: a tick advances the bit timing by one
// step, a write stores one pixel (indexes at or past the LED count are
// accepted and ignored), a fill writes one color to every entry below the
// LED count, and a show restarts the stream at the first pixel. Write, fill
// and show are refused while a transfer is running. Each item gives exactly
// one beat on the result channel with the data line level, the busy flag and
// whether the operation was carried out. The stream sends the pixels in use
// green, red, blue, most significant bit first; each bit is high for the
// zero or one high time (saturated at the period), low for the rest of the
// bit period, and a low idle period of one bit period closes the transfer.
// Each item is captured, with the registered read of the pixel memory,
// then carried out, and its result is loaded into the result register; a
// new item is accepted only once the previous one has been carried out.
// A fill writes one memory entry per cycle over the LED count in use
// (led_count clamped to LEDS) before its result is loaded; on an empty
// strip it writes nothing and finishes like any other item. The next item is
// accepted while the previous result still waits in the output register;
// while the result register stays full after that, the item waits until it
// frees up. The item channel is not ready while reset is held.
// The pixel memory has no reset; pixels must be written before they are
// shown. Configuration writes are meant for times when no item is in flight.
module ws2812_strip_driver_core #(
  parameter int LEDS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  ws_in_if.sink                         item,
  ws_out_if.source                      result,
  input  logic                          cfg_we,
  input  logic [ws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ws_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ws_pkg::*;

  // Command and status between the controller and the datapath.
  cmd_t  cmd;
  stat_t stat;

  // The controller sequences each beat: capture, execute, an optional fill
  // sweep, and a wait for the result register to free up.
  ws_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath holds the configuration registers, the pixel memory, the
  // bit timing counters and the result register.
  ws_dp #(
    .LEDS (LEDS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .op          (item.op),
    .pixel_index (item.pixel_index),
    .green       (item.green),
    .red         (item.red),
    .blue        (item.blue),
    .out_ready   (result.ready),
    .out_valid   (result.valid),
    .pin_level   (result.pin_level),
    .busy_res    (result.busy_res),
    .accepted    (result.accepted)
  );

endmodule

[hdl/ws_dp.sv]
// Datapath of the strip driver: registers, pixel memory, bit timing and result stage.
`include "assert_macros.svh"

module ws_dp #(
  parameter int LEDS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ws_pkg::cmd_t                  cmd,
  output ws_pkg::stat_t                 stat,
  input  logic                          cfg_we,
  input  logic [ws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ws_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]                    op,
  input  logic [7:0]                    pixel_index,
  input  logic [7:0]                    green,
  input  logic [7:0]                    red,
  input  logic [7:0]                    blue,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          pin_level,
  output logic                          busy_res,
  output logic                          accepted
);
  import ws_pkg::*;

  localparam int AW   = (LEDS > 1) ? $clog2(LEDS) : 1;
  localparam int CW   = $clog2(LEDS + 1);
  localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int IW   = (CW > 8) ? CW : 8;

  logic [TIME_W-1:0]  high_time_zero;
  logic [TIME_W-1:0]  high_time_one;
  logic [TIME_W-1:0]  bit_period;
  logic [COUNT_W-1:0] led_count;

  logic [23:0] pixel_store [LEDS];
  logic [23:0] rd_data;

  op_t         op_q;
  logic [7:0]  idx_q;
  logic [23:0] colour_q;

  logic          sending;
  logic          line_level;
  logic [TIME_W-1:0] tick_count;
  logic [2:0]    bit_pos;
  logic [1:0]    chan;
  logic [CW-1:0] pixel_pos;
  logic [CW-1:0] fill_pos;
  logic          ok;

  logic          sending_next;
  logic          line_next;
  logic [TIME_W-1:0] tick_next;
  logic [2:0]    bit_next;
  logic [1:0]    chan_next;
  logic [CW-1:0] pixel_next;
  logic          ok_next;
  logic          write_hit;

  logic [CMPW-1:0] led_cmp;
  logic [CMPW-1:0] leds_cmp;
  logic [CW-1:0]   used;
  logic [TIME_W-1:0] period;
  logic [TIME_W-1:0] high_sel;
  logic [TIME_W-1:0] high_sat;
  logic [TIME_W:0]   tick_inc;
  logic [7:0]  byte_sel;
  logic        bit_val;
  logic        idx_ok;
  logic        mem_we;
  logic [AW-1:0] mem_addr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      high_time_zero <= RST_HIGH_TIME_ZERO;
      high_time_one  <= RST_HIGH_TIME_ONE;
      bit_period     <= RST_BIT_PERIOD;
      led_count      <= RST_LED_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HIGH_TIME_ZERO: high_time_zero <= cfg_data;
        REG_HIGH_TIME_ONE:  high_time_one  <= cfg_data;
        REG_BIT_PERIOD:     bit_period     <= cfg_data;
        REG_LED_COUNT:      led_count      <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    led_cmp  = CMPW'(led_count);
    leds_cmp = CMPW'(LEDS);
    used     = (led_cmp > leds_cmp) ? CW'(leds_cmp) : CW'(led_cmp);
    period   = (bit_period == '0) ? TIME_W'(1) : bit_period;
    idx_ok   = IW'(idx_q) < IW'(used);
    case (chan)
      CHAN_GREEN: byte_sel = rd_data[23:16];
      CHAN_RED:   byte_sel = rd_data[15:8];
      default:    byte_sel = rd_data[7:0];
    endcase
    bit_val  = byte_sel[bit_pos];
    high_sel = bit_val ? high_time_one : high_time_zero;
    high_sat = (high_sel > period) ? period : high_sel;
    tick_inc = {1'b0, tick_count} + 1'b1;
  end

  // Effect of the captured operation on the stream state.
  always_comb begin
    sending_next = sending;
    line_next    = line_level;
    tick_next    = tick_count;
    bit_next     = bit_pos;
    chan_next    = chan;
    pixel_next   = pixel_pos;
    ok_next      = 1'b1;
    write_hit    = 1'b0;
    case (op_q)
      OP_TICK: begin
        if (sending) begin
          if (pixel_pos < used) begin
            line_next = tick_count < high_sat;
            if (tick_inc >= {1'b0, period}) begin
              tick_next = '0;
              if (bit_pos == '0) begin
                bit_next = BIT_MSB;
                if (chan == CHAN_BLUE) begin
                  chan_next  = CHAN_GREEN;
                  pixel_next = pixel_pos + 1'b1;
                end else begin
                  chan_next = chan + 1'b1;
                end
              end else begin
                bit_next = bit_pos - 1'b1;
              end
            end else begin
              tick_next = tick_inc[TIME_W-1:0];
            end
          end else begin
            line_next = 1'b0;
            if (tick_inc >= {1'b0, period}) begin
              tick_next    = '0;
              sending_next = 1'b0;
            end else begin
              tick_next = tick_inc[TIME_W-1:0];
            end
          end
        end
      end
      OP_WRITE: begin
        if (sending) begin
          ok_next = 1'b0;
        end else begin
          write_hit = idx_ok;
        end
      end
      OP_FILL: begin
        if (sending) begin
          ok_next = 1'b0;
        end
      end
      OP_SHOW: begin
        if (sending) begin
          ok_next = 1'b0;
        end else begin
          pixel_next   = '0;
          chan_next    = CHAN_GREEN;
          bit_next     = BIT_MSB;
          tick_next    = '0;
          line_next    = 1'b0;
          sending_next = used != '0;
        end
      end
      default: ;
    endcase
  end

  // Captured beat.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q     <= op_t'(op);
      idx_q    <= pixel_index;
      colour_q <= {green, red, blue};
    end
  end

  // Stream state.
  always_ff @(posedge clk) begin
    if (rst) begin
      sending    <= 1'b0;
      line_level <= 1'b0;
      tick_count <= '0;
      bit_pos    <= BIT_MSB;
      chan       <= CHAN_GREEN;
      pixel_pos  <= '0;
      ok         <= 1'b1;
      fill_pos   <= '0;
    end else begin
      if (cmd.exec) begin
        sending    <= sending_next;
        line_level <= line_next;
        tick_count <= tick_next;
        bit_pos    <= bit_next;
        chan       <= chan_next;
        pixel_pos  <= pixel_next;
        ok         <= ok_next;
      end
      if (cmd.fill_start) begin
        fill_pos <= '0;
      end else if (cmd.fill_step) begin
        fill_pos <= fill_pos + 1'b1;
      end
    end
  end

  // Pixel memory: one write port, one registered read port.
  assign mem_we   = cmd.fill_step || (cmd.exec && write_hit);
  assign mem_addr = cmd.fill_step ? fill_pos[AW-1:0] : AW'(idx_q);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pixel_store[mem_addr] <= colour_q;
    end
    if (cmd.latch) begin
      rd_data <= pixel_store[pixel_pos[AW-1:0]];
    end
  end

  // Result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_next) begin
      out_valid <= 1'b1;
      pin_level <= line_next;
      busy_res  <= sending_next;
      accepted  <= ok_next;
    end else if (cmd.out_reg) begin
      out_valid <= 1'b1;
      pin_level <= line_level;
      busy_res  <= sending;
      accepted  <= ok;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    stat.op        = op_q;
    stat.sending   = sending;
    stat.n_zero    = used == '0;
    stat.fill_last = fill_pos == CW'(used - 1'b1);
    stat.out_free  = !out_valid || out_ready;
  end

  `ASSERT_IMPL(a_idle_line_low, clk, rst, !sending, !line_level)
  `ASSERT_IMPL(a_load_when_free, clk, rst, (cmd.out_next || cmd.out_reg), stat.out_free)
  `ASSERT_IMPL(a_fill_in_range, clk, rst, cmd.fill_step, (fill_pos < used))
  `ASSERT_IMPL(a_chan_valid, clk, rst, 1'b1, (chan != 2'd3))
  `ASSERT_NEXT(a_sending_holds, clk, rst, !cmd.exec, $stable(sending))

endmodule

[hdl/ws_ctrl.sv]
// Controller state machine of the strip driver.
module ws_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  ws_pkg::stat_t stat,
  output ws_pkg::cmd_t  cmd
);
  import ws_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_EMIT
  } state_t;

  state_t state;
  logic   fill_go;

  assign fill_go = (stat.op == OP_FILL) && !stat.sending && !stat.n_zero;

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        // No beat is taken while reset is held.
        item_ready = !rst;
        cmd.latch  = item_valid && !rst;
      end
      S_EXEC: begin
        cmd.exec       = 1'b1;
        cmd.fill_start = fill_go;
        cmd.out_next   = !fill_go && stat.out_free;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
      end
      S_EMIT: begin
        cmd.out_reg = stat.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fill_go) begin
            state <= S_FILL;
          end else if (stat.out_free) begin
            state <= S_IDLE;
          end else begin
            state <= S_EMIT;
          end
        end
        S_FILL: begin
          if (stat.fill_last) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
